FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ZVE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset cycles included.
`define ZVE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: src/zve_pkg.sv
// Package of the zigzag varint encoder: item types, queue status, constants.
// No dependencies.
`timescale 1ns / 1ps

package zve_pkg;

    localparam int VALUE_WIDTH_DEF = 128;
    localparam int VALUE_WIDTH_MIN = 64;
    localparam int VALUE_WIDTH_MAX = 128;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int         PAYLOAD_BITS = 7;
    localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
    localparam logic [7:0] CONT_BIT     = 8'h80;

    typedef struct packed {
        logic [63:0]        value_low;
        logic signed [63:0] value_high;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_zve_qstat;

endpackage

FILE: src/zve_queue.sv
// Small register queue between the front and back parts of the encoder.
// Depends on zve_pkg.
`timescale 1ns / 1ps

module zve_queue import zve_pkg::*; #(
    parameter int WIDTH = VALUE_WIDTH_DEF,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output t_zve_qstat       o_stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wptr, n_wptr;
    logic [PtrW-1:0]  r_rptr, n_rptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_stat.full      = (r_count == CntW'(DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign o_pop_data       = r_mem[r_rptr];

    assign do_push = i_push & ~o_stat.full;
    assign do_pop  = i_pop & o_stat.not_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

FILE: src/zve_front.sv
// Front part: takes input transfers, sign-extends and zigzag-maps the value.
// Depends on zve_pkg.
`timescale 1ns / 1ps

module zve_front import zve_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    input  t_zve_qstat             i_q_stat,
    output logic                   o_push,
    output logic [VALUE_WIDTH-1:0] o_push_data
);

    logic                   r_valid, n_valid;
    logic [VALUE_WIDTH-1:0] r_zz, n_zz;
    logic [127:0]           full_value;
    logic                   sign_bit;
    logic                   take;

    // Bits above VALUE_WIDTH-1 are copies of the sign, so the zigzag result
    // fits in VALUE_WIDTH bits and only the low part is computed.
    assign full_value = {i_in_data.value_high, i_in_data.value_low};
    assign sign_bit   = full_value[VALUE_WIDTH-1];

    assign o_push      = r_valid & ~i_q_stat.full;
    assign o_push_data = r_zz;
    assign o_in_stall  = r_valid & i_q_stat.full;
    assign take        = i_in_valid & ~o_in_stall;

    always_comb begin
        n_valid = r_valid;
        n_zz    = r_zz;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
            n_zz    = {full_value[VALUE_WIDTH-2:0], 1'b0} ^ {VALUE_WIDTH{sign_bit}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zz <= n_zz;
    end

endmodule

FILE: src/zve_back.sv
// Back part: shifts a queued zigzag value out as base-128 bytes, one a cycle
// while the output is not stalled. Depends on zve_pkg.
`timescale 1ns / 1ps

module zve_back import zve_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_zve_qstat             i_q_stat,
    input  logic [VALUE_WIDTH-1:0] i_q_data,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data
);

    logic                   r_busy, n_busy;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;
    logic                   more, advance, emit, done;

    // More bytes follow while anything is left above the low payload group.
    assign more    = |r_rem[VALUE_WIDTH-1:PAYLOAD_BITS];
    assign advance = ~r_out_valid | ~i_out_stall;
    assign emit    = r_busy & advance;
    assign done    = emit & ~more;
    assign o_pop   = i_q_stat.not_empty & (~r_busy | done);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_busy      = r_busy;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (advance) begin
            n_out_valid = emit;
        end
        if (emit) begin
            n_out.out_byte  = (more ? CONT_BIT : 8'h00) |
                              ({1'b0, r_rem[PAYLOAD_BITS-1:0]} & PAYLOAD_MASK);
            n_out.last_byte = ~more;
            n_rem           = r_rem >> PAYLOAD_BITS;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_rem  = i_q_data;
        end else if (done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_out <= n_out;
    end

endmodule

FILE: src/zigzag_varint_encoder_128_top.sv
// Top level of the zigzag varint encoder: front, queue and back parts.
// Depends on zve_pkg, zve_front, zve_queue, zve_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one signed value
//   per transfer as value_low and a signed value_high. The value is
//   sign-extended from bit VALUE_WIDTH-1 (64..128) and zigzag-mapped.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives the
//   little-endian base-128 bytes, one per transfer; bit 7 is set on every
//   byte but the last, and last_byte marks the final one (1 to 19 bytes).
//   The first byte of an item passes the front register, a queue entry, the
//   shifter register and the output register after its input transfer.
//   Throughput: the back shifter emits one byte per cycle while the output is
//   not stalled, and starts the next item right after the last byte.
//   A two-entry queue sits between the zigzag stage and the shifter; the
//   input stalls only when the front register and the queue are both full.
//   A stalled output holds its byte; the shifter waits behind it.
//   Reset clears all valid flags; no item is in flight afterwards.
`timescale 1ns / 1ps

module zigzag_varint_encoder_128_top import zve_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int VwEff = (VALUE_WIDTH < VALUE_WIDTH_MIN) ? VALUE_WIDTH_MIN :
                           (VALUE_WIDTH > VALUE_WIDTH_MAX) ? VALUE_WIDTH_MAX :
                           VALUE_WIDTH;

    t_zve_qstat       q_stat;
    logic             push, pop;
    logic [VwEff-1:0] push_data, pop_data;

    zve_front #(
        .VALUE_WIDTH (VwEff)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    zve_queue #(
        .WIDTH (VwEff),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    zve_back #(
        .VALUE_WIDTH (VwEff)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_q_data    (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: src/zve_checker.sv
// Port-level checks of the zigzag varint encoder, bound to the top level.
// Depends on zve_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zve_checker import zve_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A stalled input transfer stays offered with the same payload.
    `ZVE_ASSERT(a_in_hold, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data), "input changed while stalled")

    // A stalled output byte holds.
    `ZVE_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "output changed while stalled")

    // On every valid byte, continuation bit and last flag disagree.
    `ZVE_ASSERT(a_cont_vs_last, o_out_valid |-> (o_out_data.out_byte[7] != o_out_data.last_byte), "continuation bit does not match last flag")

    // Bytes of one value follow each other without a gap.
    `ZVE_ASSERT(a_no_gap, o_out_valid && !i_out_stall && !o_out_data.last_byte |=> o_out_valid, "gap inside a value's bytes")

    // Nothing comes out right after reset.
    `ZVE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind zigzag_varint_encoder_128_top zve_checker u_zve_checker (.*);

FILE: dv/tb_zigzag_varint_encoder_128_top.sv
// Testbench for zigzag_varint_encoder_128_top: drives signed 128-bit values and checks
// the zigzag base-128 byte stream against an in-bench predictor. Depends on zve_pkg
// and the encoder RTL.
`timescale 1ns / 1ps

module tb_zigzag_varint_encoder_128_top;
    import zve_pkg::*;

    localparam int DUT_WIDTH  = VALUE_WIDTH_DEF;
    // Effective sign position of the block, kept within its legal range
    localparam int SIGN_WIDTH = (DUT_WIDTH < VALUE_WIDTH_MIN) ? VALUE_WIDTH_MIN :
                                (DUT_WIDTH > VALUE_WIDTH_MAX) ? VALUE_WIDTH_MAX : DUT_WIDTH;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int error_count = 0;
    int values_sent = 0;
    int bytes_checked = 0;
    int longest_encoding = 0;
    int quiet_cycles = 0;

    t_out_item pending_bytes[$];

    zigzag_varint_encoder_128_top #(
        .VALUE_WIDTH(DUT_WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Zigzag-map one value and queue its varint bytes; returns the byte count
    function automatic int zigzag_varint_bytes(input t_in_item item);
        logic [127:0] v;
        logic [127:0] upper;
        logic [127:0] z;
        t_out_item    b;
        int           n;
        v = {item.value_high, item.value_low};
        upper = ~128'h0 << SIGN_WIDTH;
        if (v[SIGN_WIDTH-1]) v = v | upper;
        else v = v & ~upper;
        z = (v << 1) ^ {128{v[127]}};
        n = 0;
        while (z > 128'd127) begin
            b.out_byte = CONT_BIT | {1'b0, z[6:0]};
            b.last_byte = 1'b0;
            pending_bytes.push_back(b);
            z = z >> PAYLOAD_BITS;
            n++;
        end
        b.out_byte = {1'b0, z[6:0]};
        b.last_byte = 1'b1;
        pending_bytes.push_back(b);
        return n + 1;
    endfunction

    // Random value of random bit length, either sign
    function automatic logic [127:0] random_value();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        r = r & ~(~128'h0 << $urandom_range(1, 128));
        if ($urandom_range(0, 1)) r = ~r;
        return r;
    endfunction

    // One input transfer, then an optional idle gap; entered just after a rising edge
    task automatic send_value(input logic [127:0] v);
        t_in_item item;
        int       n;
        item.value_low = v[63:0];
        item.value_high = v[127:64];
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        n = zigzag_varint_bytes(item);
        if (n > longest_encoding) longest_encoding = n;
        values_sent++;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic test_corner_values();
        logic [127:0] corner_values[$];
        corner_values = '{
            128'h0,
            128'h1,
            ~128'h0,
            128'd63,
            -128'sd64,
            128'd64,
            -128'sd65,
            {64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
            {64'h8000_0000_0000_0000, 64'h0},
            {64'h0, 64'h7fff_ffff_ffff_ffff},
            {64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000},
            {64'h0, 64'h8000_0000_0000_0000},
            {64'h1, 64'h0},
            {64'hffff_ffff_ffff_fffe, 64'h0},
            {64'h0, 64'hffff_ffff_ffff_ffff},
            {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555},
            {64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa}
        };
        sender_idle_pct = 26;
        receiver_stall_pct = 79;
        foreach (corner_values[i]) send_value(corner_values[i]);
    endtask

    task automatic test_random_values(input int idle_pct, input int stall_pct,
                                      input int count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_value(random_value());
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Output checker
    always @(posedge i_clk) begin
        t_out_item exp_byte;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte transfer, got byte %02h last %0b", $time,
                         o_out_data.out_byte, o_out_data.last_byte);
                error_count++;
            end else begin
                exp_byte = pending_bytes.pop_front();
                bytes_checked++;
                if (o_out_data.out_byte !== exp_byte.out_byte) begin
                    $display("%0t: out_byte mismatch, expected %02h actual %02h", $time,
                             exp_byte.out_byte, o_out_data.out_byte);
                    error_count++;
                end
                if (o_out_data.last_byte !== exp_byte.last_byte) begin
                    $display("%0t: last_byte mismatch, expected %0b actual %0b", $time,
                             exp_byte.last_byte, o_out_data.last_byte);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d bytes outstanding", $time,
                         quiet_cycles, pending_bytes.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_values();
        test_random_values(26, 79, 85);
        test_random_values(79, 26, 85);
        test_random_values(0, 0, 85);
        i_in_valid <= 1'b0;

        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Encoded %0d values into %0d checked bytes, longest encoding %0d bytes;",
                 values_sent, bytes_checked, longest_encoding);
        $display("corner values plus random lengths under three sender/receiver idle mixes.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: zigzag_varint_encoder_128_top.f
+incdir+src
src/zve_pkg.sv
src/zve_queue.sv
src/zve_front.sv
src/zve_back.sv
src/zigzag_varint_encoder_128_top.sv
src/zve_checker.sv
dv/tb_zigzag_varint_encoder_128_top.sv
